>>> rtl/htok_pkg.sv
package htok_pkg;

    // Byte constants of the request grammar.
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_DASH  = 8'h2D;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_DEL   = 8'h7F;

    // Token kind codes.
    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_VERB    = 3'd1,
        K_TARGET  = 3'd2,
        K_VERSION = 3'd3,
        K_NAME    = 3'd4,
        K_VALUE   = 3'd5
    } t_kind;

    // Parser status codes.
    typedef enum logic [1:0] {
        S_BUSY = 2'd0,
        S_DONE = 2'd1,
        S_ERR  = 2'd2
    } t_status;

    // Character classes of one byte.
    typedef struct packed {
        logic ctl;
        logic up;
        logic name;
        logic sp;
        logic cr;
        logic lf;
        logic colon;
    } t_cls;

    // One result beat.
    typedef struct packed {
        t_status    status;
        logic       pair_end;
        logic [7:0] tok_byte;
        t_kind      kind;
    } t_res;

endpackage

>>> rtl/http_request_tokenizer_core.sv
// Channel  | Direction | tdata          | tuser                          | tlast
// ---------+-----------+----------------+--------------------------------+---------
// s (req)  | in        | rx_byte [7:0]  | first [0]                      | -
// m (tok)  | out       | tok_byte [7:0] | kind [2:0], status [4:3]       | pair_end
//
// One beat in gives exactly one beat out; one beat per cycle is sustained
// while the master takes beats. A beat passes an input register, then a
// result register; character classes are worked out before the input register.
// The parse state register steps when a beat moves into the result register.
// Reset is synchronous and active low and returns the parser to the start of a
// request. A stall on the master side holds the result, then backs up the
// input register, and only then drops o_s_tready.
module http_request_tokenizer_core
    import htok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic       i_s_tuser,   // [0] first
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] tok_byte
    output logic [4:0] o_m_tuser,   // [2:0] kind, [4:3] status
    output logic       o_m_tlast
);

    t_cls       in_cls;
    t_cls       r_cls;
    logic [7:0] r_byte;
    logic       r_first;
    logic       r_in_valid;
    t_res       fsm_res;
    t_res       r_res;
    logic       r_out_valid;
    logic       out_free;
    logic       adv;

    // Handshake: the result register frees up when empty or being taken.
    assign out_free   = !r_out_valid || i_m_tready;
    assign adv        = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    // Character classes of the incoming byte.
    htok_classify u_cls (
        .i_byte (i_s_tdata),
        .o_cls  (in_cls)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_byte  <= i_s_tdata;
            r_first <= i_s_tuser;
            r_cls   <= in_cls;
        end
    end

    // Parser state machine.
    htok_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_byte),
        .i_first (r_first),
        .i_cls   (r_cls),
        .o_res   (fsm_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (adv) begin
            r_res <= fsm_res;
        end
    end

    // Master-side fields.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_res.tok_byte;
    assign o_m_tuser  = {r_res.status, r_res.kind};
    assign o_m_tlast  = r_res.pair_end;

endmodule

>>> rtl/htok_classify.sv
module htok_classify
    import htok_pkg::*;
(
    input  logic [7:0] i_byte,
    output t_cls       o_cls
);

    logic is_up;
    logic is_low;
    logic is_dig;

    // Letter and digit ranges.
    assign is_up  = (i_byte >= 8'h41) && (i_byte <= 8'h5A);
    assign is_low = (i_byte >= 8'h61) && (i_byte <= 8'h7A);
    assign is_dig = (i_byte >= 8'h30) && (i_byte <= 8'h39);

    // Class flags; bytes above 127 count as printable.
    always_comb begin
        o_cls.ctl   = (i_byte < 8'h20) || (i_byte == C_DEL);
        o_cls.up    = is_up;
        o_cls.name  = is_up || is_low || is_dig || (i_byte == C_DASH);
        o_cls.sp    = (i_byte == C_SPACE);
        o_cls.cr    = (i_byte == C_CR);
        o_cls.lf    = (i_byte == C_LF);
        o_cls.colon = (i_byte == C_COLON);
    end

endmodule

>>> rtl/htok_fsm.sv
module htok_fsm
    import htok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    input  t_cls       i_cls,
    output t_res       o_res
);

    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_VERB   = 4'd1,
        ST_SP0    = 4'd2,
        ST_TARGET = 4'd3,
        ST_SP1    = 4'd4,
        ST_VER    = 4'd5,
        ST_LF0    = 4'd6,
        ST_LINE   = 4'd7,
        ST_NAME   = 4'd8,
        ST_SP2    = 4'd9,
        ST_VALUE  = 4'd10,
        ST_LF1    = 4'd11,
        ST_LF2    = 4'd12,
        ST_DONE   = 4'd13,
        ST_ERR    = 4'd14
    } t_pst;

    t_pst  r_state;
    t_pst  n_state;
    t_pst  st_cur;
    t_pst  st_nxt;
    t_kind kind;
    logic  pend;
    logic  err;

    // A first byte restarts the parse at the start of the request line.
    assign st_cur = i_first ? ST_START : r_state;

    // Grammar walk for one byte.
    always_comb begin
        st_nxt = st_cur;
        kind   = K_NONE;
        pend   = 1'b0;
        err    = 1'b0;
        case (st_cur)
            ST_START: begin
                if (i_cls.up) begin
                    kind   = K_VERB;
                    st_nxt = ST_VERB;
                end else begin
                    err = 1'b1;
                end
            end
            ST_VERB: begin
                if (i_cls.up) kind = K_VERB;
                else if (i_cls.sp) st_nxt = ST_SP0;
                else err = 1'b1;
            end
            ST_SP0: begin
                if (!i_cls.sp) begin
                    if (i_cls.ctl) begin
                        err = 1'b1;
                    end else begin
                        kind   = K_TARGET;
                        st_nxt = ST_TARGET;
                    end
                end
            end
            ST_TARGET: begin
                if (i_cls.sp) st_nxt = ST_SP1;
                else if (i_cls.ctl) err = 1'b1;
                else kind = K_TARGET;
            end
            ST_SP1: begin
                if (!i_cls.sp) begin
                    if (i_cls.ctl) begin
                        err = 1'b1;
                    end else begin
                        kind   = K_VERSION;
                        st_nxt = ST_VER;
                    end
                end
            end
            ST_VER: begin
                if (i_cls.cr) st_nxt = ST_LF0;
                else if (i_cls.ctl || i_cls.sp) err = 1'b1;
                else kind = K_VERSION;
            end
            ST_LF0: begin
                if (i_cls.lf) st_nxt = ST_LINE;
            end
            ST_LINE: begin
                if (i_cls.cr) begin
                    st_nxt = ST_LF2;
                end else if (i_cls.name) begin
                    kind   = K_NAME;
                    st_nxt = ST_NAME;
                end
            end
            ST_NAME: begin
                if (i_cls.name) kind = K_NAME;
                else if (i_cls.colon) st_nxt = ST_SP2;
            end
            ST_SP2: begin
                if (!i_cls.sp) begin
                    if (i_cls.ctl) begin
                        err = 1'b1;
                    end else begin
                        kind   = K_VALUE;
                        st_nxt = ST_VALUE;
                    end
                end
            end
            ST_VALUE: begin
                if (i_cls.cr) begin
                    pend   = 1'b1;
                    st_nxt = ST_LF1;
                end else if (i_cls.ctl) begin
                    err = 1'b1;
                end else begin
                    kind = K_VALUE;
                end
            end
            ST_LF1: begin
                if (i_cls.lf) st_nxt = ST_LINE;
            end
            ST_LF2: begin
                if (i_cls.lf) st_nxt = ST_DONE;
                else err = 1'b1;
            end
            ST_DONE: begin
                st_nxt = ST_DONE;
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    // Error override and the result fields.
    always_comb begin
        n_state        = err ? ST_ERR : st_nxt;
        o_res.kind     = err ? K_NONE : kind;
        o_res.pair_end = err ? 1'b0 : pend;
        o_res.tok_byte = (o_res.kind != K_NONE) ? i_byte : 8'h00;
        if (n_state == ST_ERR) o_res.status = S_ERR;
        else if (n_state == ST_DONE) o_res.status = S_DONE;
        else o_res.status = S_BUSY;
    end

    // State register, stepped once per processed beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

    // A tagged byte only occurs while the request is still in progress.
    a_kind_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.kind != K_NONE) |-> (o_res.status == S_BUSY))
        else $error("token byte reported outside an open request");

    // A pair end only comes from the CR that closes a header value.
    a_pair_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.pair_end |-> (st_cur == ST_VALUE) && i_cls.cr && (n_state == ST_LF1))
        else $error("pair end without closing CR of a value");

    // Errors stick until a first byte restarts the parse.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_adv) && ($past(n_state) == ST_ERR))
            |-> (r_state == ST_ERR))
        else $error("error state left without a restart");

endmodule
